[hdl/char_lcd_nibble_write_sequencer_unit_defines.svh]
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CHLCD_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("chlcd check failed");

// next-cycle implication, checked out of reset
`define CHLCD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("chlcd check failed");

`endif

[hdl/chlcd_pkg.sv]
package chlcd_pkg;

  localparam int CfgWidth          = 10;
  localparam int HoldWidth         = 11;
  localparam int NibWidth          = 4;
  localparam int ByteWidth         = 8;
  localparam int PostWidth         = 7;
  localparam int CfgIndexWidth     = 3;
  localparam int QueueDepthDefault = 4;
  localparam int InitCount         = 8;

  localparam logic [CfgWidth-1:0] DATA_SETUP_RESET    = 10'd100;
  localparam logic [CfgWidth-1:0] CMD_SETUP_RESET     = 10'd10;
  localparam logic [CfgWidth-1:0] ENABLE_LEAD_RESET   = 10'd5;
  localparam logic [CfgWidth-1:0] ENABLE_GAP_RESET    = 10'd20;
  localparam logic [CfgWidth-1:0] DATA_TAIL_RESET     = 10'd50;
  localparam logic [CfgWidth-1:0] POWER_UP_WAIT_RESET = 10'd500;

  localparam logic [ByteWidth-1:0] CURSOR_BASE  = 8'h80;
  localparam logic [ByteWidth-1:0] LINE2_OFFSET = 8'h40;
  localparam logic [1:0]           LINE_TWO     = 2'd2;

  localparam logic [PostWidth-1:0] POST_NONE   = 7'd0;
  localparam logic [PostWidth-1:0] POST_LONG   = 7'd100;
  localparam logic [PostWidth-1:0] POST_SHORT  = 7'd50;
  localparam logic [PostWidth-1:0] POST_CURSOR = 7'd100;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_DATA   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_INIT   = 2'd3
  } opcode_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DATA_SETUP    = 3'd0,
    CFG_CMD_SETUP     = 3'd1,
    CFG_ENABLE_LEAD   = 3'd2,
    CFG_ENABLE_GAP    = 3'd3,
    CFG_DATA_TAIL     = 3'd4,
    CFG_POWER_UP_WAIT = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [CfgWidth-1:0] data_setup;
    logic [CfgWidth-1:0] cmd_setup;
    logic [CfgWidth-1:0] enable_lead;
    logic [CfgWidth-1:0] enable_gap;
    logic [CfgWidth-1:0] data_tail;
    logic [CfgWidth-1:0] power_up_wait;
  } cfg_t;

  typedef enum logic {
    JOB_WAIT = 1'b0,
    JOB_BYTE = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t              kind;
    logic                   rs;
    logic [ByteWidth-1:0]   value;
    logic [PostWidth-1:0]   post_us;
    logic                   last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    F_IDLE = 1'b0,
    F_INIT = 1'b1
  } front_state_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } back_state_t;

  typedef enum logic [2:0] {
    ST_SETUP  = 3'd0,
    ST_EN_HI  = 3'd1,
    ST_NIB_HI = 3'd2,
    ST_GAP    = 3'd3,
    ST_EN_LO  = 3'd4,
    ST_NIB_LO = 3'd5,
    ST_TAIL   = 3'd6
  } step_t;

  function automatic logic [ByteWidth-1:0] init_cmd(input logic [2:0] idx);
    logic [ByteWidth-1:0] c;
    case (idx)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h30;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h20;
      3'd4:    c = 8'h28;
      3'd5:    c = 8'h0C;
      3'd6:    c = 8'h01;
      default: c = 8'h02;
    endcase
    return c;
  endfunction

  function automatic logic [PostWidth-1:0] init_post(input logic [2:0] idx);
    logic [PostWidth-1:0] p;
    case (idx)
      3'd0, 3'd3: p = POST_LONG;
      default:    p = POST_SHORT;
    endcase
    return p;
  endfunction

endpackage

[hdl/chlcd_in_if.sv]
interface chlcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic [1:0] line_select;
  logic [5:0] column;

  modport source(output valid, output opcode, output byte_value, output line_select,
                 output column, input ready);
  modport sink(input valid, input opcode, input byte_value, input line_select,
               input column, output ready);
endinterface

[hdl/chlcd_out_if.sv]
interface chlcd_out_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        read_write;
  logic        enable_pin;
  logic [3:0]  bus_nibble;
  logic [10:0] hold_us;
  logic        last_event;

  modport source(output valid, output reg_select, output read_write, output enable_pin,
                 output bus_nibble, output hold_us, output last_event, input ready);
  modport sink(input valid, input reg_select, input read_write, input enable_pin,
               input bus_nibble, input hold_us, input last_event, output ready);
endinterface

[hdl/chlcd_cfg_if.sv]
interface chlcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [9:0] wdata;

  modport source(output valid, output reg_index, output wdata, input ready);
  modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

[hdl/char_lcd_nibble_write_sequencer_unit.sv]
// character lcd write sequencer, 4-bit bus
// in_ch: one request per item (command byte, data byte, set cursor, init)
// out_ch: one pin event per item (rs, rw, e, d4..d7, hold time, last flag)
// cfg_ch: timing register writes, always ready, applied next cycle
// a front end splits requests into byte jobs (init gives a wait job and
// eight command jobs) and pushes them into a small job queue
// the back end pops jobs and, while the output slot is free, issues one
// pin event per cycle through an output register: 7 events per byte job,
// 1 for the init wait (57 for init); queued jobs follow one another with
// no gap. the first event of a request passes the queue, the job register
// and the output register when the back end is idle, and comes later when
// the back end is still busy with earlier jobs
// in_ch.ready falls while the queue is full or init jobs are being queued
// when out_ch.ready is low the pending event holds and the back end waits;
// the front end keeps filling the queue until it is full
// reset clears the queue, the held rs and nibble levels, and loads the
// timing registers with their defaults
module char_lcd_nibble_write_sequencer_unit
  import chlcd_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  chlcd_in_if.sink    in_ch,
  chlcd_out_if.source out_ch,
  chlcd_cfg_if.sink   cfg_ch
);

`include "char_lcd_nibble_write_sequencer_unit_defines.svh"

  cfg_t      cfg_r;
  q_status_t q_status;
  logic      push, pop;
  job_t      push_job, pop_job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{data_setup:    DATA_SETUP_RESET,
                 cmd_setup:     CMD_SETUP_RESET,
                 enable_lead:   ENABLE_LEAD_RESET,
                 enable_gap:    ENABLE_GAP_RESET,
                 data_tail:     DATA_TAIL_RESET,
                 power_up_wait: POWER_UP_WAIT_RESET};
    end else if (cfg_ch.valid) begin
      case (cfg_index_t'(cfg_ch.reg_index))
        CFG_DATA_SETUP:    cfg_r.data_setup    <= cfg_ch.wdata;
        CFG_CMD_SETUP:     cfg_r.cmd_setup     <= cfg_ch.wdata;
        CFG_ENABLE_LEAD:   cfg_r.enable_lead   <= cfg_ch.wdata;
        CFG_ENABLE_GAP:    cfg_r.enable_gap    <= cfg_ch.wdata;
        CFG_DATA_TAIL:     cfg_r.data_tail     <= cfg_ch.wdata;
        CFG_POWER_UP_WAIT: cfg_r.power_up_wait <= cfg_ch.wdata;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  chlcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  chlcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  chlcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pop_job  (pop_job),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  `CHLCD_ASSERT_NOW(a_no_push_when_full, q_status.full, !push)
  `CHLCD_ASSERT_NOW(a_no_pop_when_empty, q_status.empty, !pop)
  `CHLCD_ASSERT_NOW(a_last_has_enable_low, out_ch.valid && out_ch.last_event,
                    !out_ch.enable_pin)
  `CHLCD_ASSERT_NEXT(a_init_blocks_input,
                     in_ch.valid && in_ch.ready && in_ch.opcode == OP_INIT, !in_ch.ready)

endmodule

[hdl/chlcd_front.sv]
module chlcd_front
  import chlcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  chlcd_in_if.sink  in_ch,
  input  q_status_t q_status,
  output logic      push,
  output job_t      push_job
);

  localparam logic [2:0] InitLast = 3'(InitCount - 1);

  front_state_t state_r, state_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         accept;
  logic [ByteWidth-1:0] cursor_addr;

  assign accept = in_ch.valid && in_ch.ready;
  assign cursor_addr = CURSOR_BASE
                     + ((in_ch.line_select == LINE_TWO) ? LINE2_OFFSET : 8'h00)
                     + {2'b00, in_ch.column};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && opcode_t'(in_ch.opcode) == OP_INIT) state_nxt = F_INIT;
      end
      F_INIT: begin
        if (!q_status.full && idx_r == InitLast) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    push        = 1'b0;
    push_job    = '{kind: JOB_BYTE, rs: 1'b0, value: '0, post_us: POST_NONE, last: 1'b1};
    idx_nxt     = idx_r;
    unique case (state_r)
      F_IDLE: begin
        in_ch.ready = !q_status.full;
        if (in_ch.valid && !q_status.full) begin
          push = 1'b1;
          unique case (opcode_t'(in_ch.opcode))
            OP_CMD: begin
              push_job.value = in_ch.byte_value;
            end
            OP_DATA: begin
              push_job.rs    = 1'b1;
              push_job.value = in_ch.byte_value;
            end
            OP_CURSOR: begin
              push_job.value   = cursor_addr;
              push_job.post_us = POST_CURSOR;
            end
            OP_INIT: begin
              push_job.kind = JOB_WAIT;
              push_job.last = 1'b0;
              idx_nxt       = '0;
            end
            default: push = 1'b0;
          endcase
        end
      end
      F_INIT: begin
        if (!q_status.full) begin
          push             = 1'b1;
          push_job.value   = init_cmd(idx_r);
          push_job.post_us = init_post(idx_r);
          push_job.last    = (idx_r == InitLast);
          idx_nxt          = idx_r + 3'd1;
        end
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[hdl/chlcd_queue.sv]
module chlcd_queue
  import chlcd_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t q_status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign q_status.full  = (count_r == CntFull);
  assign q_status.empty = (count_r == '0);
  assign pop_job        = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrOne;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrOne;
      case ({push, pop})
        2'b10:   count_r <= count_r + CntOne;
        2'b01:   count_r <= count_r - CntOne;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/chlcd_back.sv]
module chlcd_back
  import chlcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  job_t       pop_job,
  input  q_status_t  q_status,
  output logic       pop,
  chlcd_out_if.source out_ch
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  step_t       step_r, step_nxt;
  logic        sel_r;
  logic [NibWidth-1:0] nib_r;

  logic                 out_valid_r;
  logic                 out_sel_r, out_en_r, out_last_r;
  logic [NibWidth-1:0]  out_nib_r;
  logic [HoldWidth-1:0] out_hold_r;

  logic                 slot_free, fire, ev_done;
  logic                 ev_sel, ev_en, ev_last;
  logic [NibWidth-1:0]  ev_nib;
  logic [HoldWidth-1:0] ev_hold, setup_w, tail_w;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign setup_w   = {1'b0, job_r.rs ? cfg.data_setup : cfg.cmd_setup};
  assign tail_w    = {1'b0, job_r.rs ? cfg.data_tail : cfg.enable_gap}
                   + {{(HoldWidth-PostWidth){1'b0}}, job_r.post_us};

  // pin event for the current step
  always_comb begin
    ev_sel  = sel_r;
    ev_nib  = nib_r;
    ev_en   = 1'b0;
    ev_hold = '0;
    ev_last = 1'b0;
    ev_done = 1'b0;
    if (job_r.kind == JOB_WAIT) begin
      ev_hold = {1'b0, cfg.power_up_wait};
      ev_last = job_r.last;
      ev_done = 1'b1;
    end else begin
      unique case (step_r)
        ST_SETUP: begin
          ev_sel  = job_r.rs;
          ev_hold = setup_w;
        end
        ST_EN_HI, ST_EN_LO: begin
          ev_en   = 1'b1;
          ev_hold = {1'b0, cfg.enable_lead};
        end
        ST_NIB_HI: begin
          ev_en   = 1'b1;
          ev_nib  = job_r.value[ByteWidth-1:NibWidth];
          ev_hold = setup_w;
        end
        ST_GAP: begin
          ev_hold = {1'b0, cfg.enable_gap};
        end
        ST_NIB_LO: begin
          ev_en   = 1'b1;
          ev_nib  = job_r.value[NibWidth-1:0];
          ev_hold = setup_w;
        end
        ST_TAIL: begin
          ev_hold = tail_w;
          ev_last = job_r.last;
          ev_done = 1'b1;
        end
        default: ev_done = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) state_nxt = B_RUN;
      end
      B_RUN: begin
        if (slot_free && ev_done && q_status.empty) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    fire     = 1'b0;
    pop      = 1'b0;
    step_nxt = step_r;
    unique case (state_r)
      B_IDLE: begin
        pop = !q_status.empty;
      end
      B_RUN: begin
        fire = slot_free;
        pop  = slot_free && ev_done && !q_status.empty;
      end
      default: pop = 1'b0;
    endcase
    if (pop) begin
      step_nxt = ST_SETUP;
    end else if (fire) begin
      step_nxt = step_t'(step_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= ST_SETUP;
      sel_r       <= 1'b0;
      nib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (fire) begin
        sel_r       <= ev_sel;
        nib_r       <= ev_nib;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= pop_job;
    if (fire) begin
      out_sel_r  <= ev_sel;
      out_en_r   <= ev_en;
      out_nib_r  <= ev_nib;
      out_hold_r <= ev_hold;
      out_last_r <= ev_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reg_select = out_sel_r;
  assign out_ch.read_write = 1'b0;
  assign out_ch.enable_pin = out_en_r;
  assign out_ch.bus_nibble = out_nib_r;
  assign out_ch.hold_us    = out_hold_r;
  assign out_ch.last_event = out_last_r;

endmodule
